// ===== sv/rrt_pkg.sv =====
// Package: shared constants and types for the tree extender.
package rrt_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int IDX_BITS   = $clog2(MAX_NODES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int COORD_BITS = 16;

    localparam logic [2:0] ST_ROOT    = 3'd0;
    localparam logic [2:0] ST_NODE    = 3'd1;
    localparam logic [2:0] ST_GOAL    = 3'd2;
    localparam logic [2:0] ST_REJECT  = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [2:0] REG_GOAL_X     = 3'd0;
    localparam logic [2:0] REG_GOAL_Y     = 3'd1;
    localparam logic [2:0] REG_STEP       = 3'd2;
    localparam logic [2:0] REG_OBST_X     = 3'd3;
    localparam logic [2:0] REG_OBST_Y     = 3'd4;
    localparam logic [2:0] REG_OBST_W     = 3'd5;
    localparam logic [2:0] REG_OBST_H     = 3'd6;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd7;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [IDX_BITS-1:0]          t_idx;

endpackage

// ===== sv/rrt_tree_extend.sv =====
// Top level: rapidly-exploring random tree extender with node memory.
//
//  channel | direction | signals
//  --------+-----------+--------------------------------------------------
//  input   | in        | i_valid, o_stall, i_mode, i_point_x, i_point_y
//  output  | out       | o_valid, i_stall, o_status, o_node_index, o_node_x,
//          |           | o_node_y, o_parent_index, o_last
//  config  | in        | i_cfg_we, i_cfg_index, i_cfg_data
//
// A start transfer puts its result in the output register as it is taken.
// A sample first scans the node memory for the nearest node (one memory
// read a cycle); then it takes the sample itself when it is within reach,
// or else forms the square root and, for each of the two axes, a product
// step, the divide steps and a finish step; then it checks and writes.
// Reset clears the control and configuration registers; node memory is
// never cleared, since entries at or above the node count are never read.
// A result waits in the output register while stalled; a goal node follows
// its node result, and the block holds o_stall until both are taken.
module rrt_tree_extend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic signed [15:0]            i_point_x,
    input  logic signed [15:0]            i_point_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [9:0]                    o_node_index,
    output logic signed [15:0]            o_node_x,
    output logic signed [15:0]            o_node_y,
    output logic [9:0]                    o_parent_index,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import rrt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_SQRT   = 4'd2;
    localparam logic [3:0] S_DIVX   = 4'd3;
    localparam logic [3:0] S_DIVY   = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_OUT1   = 4'd6;
    localparam logic [3:0] S_OUT2   = 4'd7;
    localparam logic [3:0] S_MUL    = 4'd10;

    // configuration
    logic signed [15:0] r_goal_x, r_goal_y, r_obst_x, r_obst_y;
    logic [14:0]        r_step, r_obst_w, r_obst_h;
    logic [9:0]         r_iter_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= 16'sd1280; r_goal_y <= 16'sd1280;
            r_step <= 15'd128;
            r_obst_x <= 16'sd512; r_obst_y <= 16'sd512;
            r_obst_w <= 15'd256; r_obst_h <= 15'd256;
            r_iter_limit <= 10'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GOAL_X:     r_goal_x <= i_cfg_data;
                REG_GOAL_Y:     r_goal_y <= i_cfg_data;
                REG_STEP:       r_step <= i_cfg_data[14:0];
                REG_OBST_X:     r_obst_x <= i_cfg_data;
                REG_OBST_Y:     r_obst_y <= i_cfg_data;
                REG_OBST_W:     r_obst_w <= i_cfg_data[14:0];
                REG_OBST_H:     r_obst_h <= i_cfg_data[14:0];
                REG_ITER_LIMIT: r_iter_limit <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // node memory: x, y, parent in one word
    logic [2*COORD_BITS+IDX_BITS-1:0] mem [MAX_NODES];
    logic                             mem_we;
    t_idx                             mem_waddr, mem_raddr;
    logic [2*COORD_BITS+IDX_BITS-1:0] mem_wdata, r_mem_q;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_mem_q <= mem[mem_raddr];
    end

    t_coord q_x, q_y;
    assign q_x = r_mem_q[2*COORD_BITS+IDX_BITS-1 -: COORD_BITS];
    assign q_y = r_mem_q[COORD_BITS+IDX_BITS-1 -: COORD_BITS];

    // control and working registers
    logic [3:0]          r_state;
    logic [CNT_BITS-1:0] r_count;
    logic [9:0]          r_samples;
    logic                r_goal_hit, r_started;
    t_coord              r_px, r_py, r_nx, r_ny, r_bx, r_by;
    logic [CNT_BITS-1:0] r_scan;          // next address to issue
    logic                r_rd_pend;       // read data valid for r_cmp_idx
    t_idx                r_cmp_idx, r_near;
    logic [33:0]         r_best;
    logic                r_have_best;
    // sqrt
    logic [33:0]         r_sq_n, r_sq_res, r_sq_bit;
    // divide
    logic signed [17:0]  r_dx, r_dy;
    logic [33:0]         r_dividend;
    logic [34:0]         r_rem;
    logic [33:0]         r_quot;
    logic [16:0]         r_div_den;
    logic [5:0]          r_div_cnt;
    logic                r_div_neg;
    logic [33:0]         r_dist_goal;
    // output register
    logic                r_ovalid;
    logic [2:0]          r_ostatus;
    t_idx                r_oidx, r_opar;
    t_coord              r_ox, r_oy;
    logic                r_olast;
    logic                r_goal_next;

    assign o_valid = r_ovalid;
    assign o_status = r_ostatus;
    assign o_node_index = r_oidx;
    assign o_node_x = r_ox;
    assign o_node_y = r_oy;
    assign o_parent_index = r_opar;
    assign o_last = r_olast;
    assign o_stall = (r_state != S_IDLE) || r_ovalid || r_goal_next;

    logic in_fire, out_fire;
    assign in_fire  = i_valid && !o_stall;
    assign out_fire = r_ovalid && !i_stall;

    logic [29:0] step2;
    assign step2 = 30'(r_step) * 30'(r_step);

    // squared distance from scanned node to sample
    logic signed [16:0] sd_x, sd_y;
    logic [33:0]        sd2;
    assign sd_x = 17'(q_x) - 17'(r_px);
    assign sd_y = 17'(q_y) - 17'(r_py);
    assign sd2  = 34'(sd_x) * 34'(sd_x) + 34'(sd_y) * 34'(sd_y);

    // sqrt step
    logic [33:0] sq_try;
    assign sq_try = r_sq_res + r_sq_bit;

    // divide step (restoring)
    logic [34:0] div_sh, div_sub;
    assign div_sh  = {r_rem[33:0], r_dividend[33]};
    assign div_sub = div_sh - 35'(r_div_den);

    // goal distance
    logic signed [16:0] gd_x, gd_y;
    assign gd_x = 17'(r_nx) - 17'(r_goal_x);
    assign gd_y = 17'(r_ny) - 17'(r_goal_y);

    // obstacle test
    logic signed [17:0] ox_hi, oy_hi;
    logic               hit;
    assign ox_hi = 18'(r_obst_x) + 18'(r_obst_w);
    assign oy_hi = 18'(r_obst_y) + 18'(r_obst_h);
    assign hit = (18'(r_nx) >= 18'(r_obst_x)) && (18'(r_nx) <= ox_hi) &&
                 (18'(r_ny) >= 18'(r_obst_y)) && (18'(r_ny) <= oy_hi);

    // signed quotient and new coordinate
    logic signed [34:0] q_signed;
    assign q_signed = r_div_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});

    logic [33:0] prod_abs;
    logic        mul_neg;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_BITS-1:0];
        mem_wdata = {r_nx, r_ny, r_near};
        mem_raddr = r_scan[IDX_BITS-1:0];
        if (r_state == S_IDLE && in_fire && !i_mode) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {i_point_x, i_point_y, t_idx'(0)};
        end else if (r_state == S_OUT1 && !hit) begin
            mem_we = 1'b1;
        end else if (r_state == S_OUT2) begin
            mem_we    = 1'b1;
            mem_wdata = {r_goal_x, r_goal_y, r_count[IDX_BITS-1:0] - t_idx'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_samples <= '0;
            r_goal_hit <= 1'b0;
            r_started <= 1'b0;
            r_ovalid <= 1'b0;
            r_rd_pend <= 1'b0;
            r_goal_next <= 1'b0;
        end else begin
            // a queued goal node reloads the output register instead
            if (out_fire && !r_goal_next) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (r_goal_next && (out_fire || !r_ovalid)) begin
                        // deliver the queued goal node
                        r_goal_next <= 1'b0;
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_GOAL;
                        r_oidx    <= r_count[IDX_BITS-1:0] - t_idx'(1);
                        r_ox      <= r_goal_x;
                        r_oy      <= r_goal_y;
                        r_opar    <= r_count[IDX_BITS-1:0] - t_idx'(2);
                        r_olast   <= 1'b1;
                    end else if (in_fire) begin
                        r_px <= i_point_x;
                        r_py <= i_point_y;
                        if (!i_mode) begin
                            r_count <= CNT_BITS'(1);
                            r_samples <= '0;
                            r_goal_hit <= 1'b0;
                            r_started <= 1'b1;
                            r_ovalid <= 1'b1;
                            r_ostatus <= ST_ROOT;
                            r_oidx <= '0; r_opar <= '0;
                            r_ox <= i_point_x; r_oy <= i_point_y;
                            r_olast <= 1'b1;
                        end else if (!r_started || r_goal_hit ||
                                     r_samples >= r_iter_limit ||
                                     r_count >= CNT_BITS'(MAX_NODES) ||
                                     r_count == '0) begin
                            r_ovalid <= 1'b1;
                            r_ostatus <= ST_IGNORED;
                            r_oidx <= '0; r_opar <= '0;
                            r_ox <= '0; r_oy <= '0;
                            r_olast <= 1'b1;
                        end else begin
                            r_scan <= '0;
                            r_rd_pend <= 1'b0;
                            r_have_best <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue one read a cycle, compare the previous one
                    if (r_scan < r_count) begin
                        r_scan <= r_scan + CNT_BITS'(1);
                        r_cmp_idx <= r_scan[IDX_BITS-1:0];
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_rd_pend <= 1'b0;
                    end
                    if (r_rd_pend) begin
                        if (!r_have_best || sd2 < r_best) begin
                            r_best <= sd2;
                            r_near <= r_cmp_idx;
                            r_bx <= q_x;
                            r_by <= q_y;
                            r_have_best <= 1'b1;
                        end
                    end
                    if (r_rd_pend && r_scan >= r_count) begin
                        r_state <= S_SQRT;
                        r_sq_n <= (!r_have_best || sd2 < r_best) ? sd2 : r_best;
                        r_sq_res <= '0;
                        r_sq_bit <= 34'h1 << 32;
                    end
                end
                S_SQRT: begin
                    if (r_best <= 34'(step2)) begin
                        r_nx <= r_px; r_ny <= r_py;
                        r_state <= S_CHECK;
                    end else if (r_sq_bit == '0) begin
                        r_div_den <= (r_sq_res == '0) ? 17'd1 : r_sq_res[16:0];
                        r_dx <= 18'(r_px) - 18'(r_bx);
                        r_dy <= 18'(r_py) - 18'(r_by);
                        r_state <= S_MUL;
                        r_div_cnt <= '0;
                    end else begin
                        if (r_sq_n >= sq_try) begin
                            r_sq_n <= r_sq_n - sq_try;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end
                S_MUL: begin
                    // form |d| * step for the current axis
                    r_dividend <= prod_abs;
                    r_div_neg <= mul_neg;
                    r_rem <= '0;
                    r_quot <= '0;
                    r_div_cnt <= '0;
                    r_state <= (r_div_cnt[0]) ? S_DIVY : S_DIVX;
                end
                S_DIVX, S_DIVY: begin
                    if (r_div_cnt == 6'd34) begin
                        if (r_state == S_DIVX) begin
                            r_nx <= COORD_BITS'(35'(r_bx) + q_signed);
                            r_div_cnt <= 6'd1;
                            r_state <= S_MUL;
                        end else begin
                            r_ny <= COORD_BITS'(35'(r_by) + q_signed);
                            r_state <= S_CHECK;
                        end
                    end else begin
                        r_dividend <= r_dividend << 1;
                        if (!div_sub[34]) begin
                            r_rem <= div_sub;
                            r_quot <= {r_quot[32:0], 1'b1};
                        end else begin
                            r_rem <= div_sh;
                            r_quot <= {r_quot[32:0], 1'b0};
                        end
                        r_div_cnt <= r_div_cnt + 6'd1;
                    end
                end
                S_CHECK: begin
                    r_samples <= r_samples + 10'd1;
                    r_dist_goal <= 34'(gd_x) * 34'(gd_x) + 34'(gd_y) * 34'(gd_y);
                    r_state <= S_OUT1;
                end
                S_OUT1: begin
                    r_ovalid <= 1'b1;
                    r_ox <= r_nx; r_oy <= r_ny;
                    r_opar <= r_near;
                    if (hit) begin
                        r_ostatus <= ST_REJECT;
                        r_oidx <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_ostatus <= ST_NODE;
                        r_oidx <= r_count[IDX_BITS-1:0];
                        r_count <= r_count + CNT_BITS'(1);
                        if (r_dist_goal <= 34'(step2) &&
                            (r_count + CNT_BITS'(1)) < CNT_BITS'(MAX_NODES)) begin
                            r_olast <= 1'b0;
                            r_state <= S_OUT2;
                        end else begin
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT2: begin
                    // write the goal node, queue its result
                    r_count <= r_count + CNT_BITS'(1);
                    r_goal_hit <= 1'b1;
                    r_goal_next <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // |d| * step for the axis in work (x on first pass, y on second)
    logic signed [17:0] d_sel;
    logic [17:0]        d_abs;
    always_comb begin
        d_sel    = r_div_cnt[0] ? r_dy : r_dx;
        mul_neg  = d_sel[17];
        d_abs    = mul_neg ? 18'(-d_sel) : 18'(d_sel);
        prod_abs = 34'(32'(d_abs) * 32'(r_step));
    end

endmodule

// ===== verif/rrt_tree_extend_checker.sv =====
// Checker for the tree extender: shadow tree, result prediction and comparison.
`timescale 1ns / 1ps

module rrt_tree_extend_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic               i_mode,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_status,
    input  logic [9:0]         i_node_index,
    input  logic signed [15:0] i_node_x,
    input  logic signed [15:0] i_node_y,
    input  logic [9:0]         i_parent_index,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_cnt,
    output int                 o_pending
);
    import rrt_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [9:0]  node_index;
        logic [15:0] node_x;
        logic [15:0] node_y;
        logic [9:0]  parent_index;
        logic        last;
    } t_placement;

    t_placement placements_due[$];

    // shadow tree
    longint     node_xs [MAX_NODES];
    longint     node_ys [MAX_NODES];
    int         node_cnt;
    int         samples_done;
    bit         goal_hit;
    bit         started;

    // shadow registers
    t_coord      goal_x, goal_y, obst_x, obst_y;
    logic [14:0] step_lim, obst_w, obst_h;
    logic [9:0]  iter_lim;

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    -= root + bitv;
                root  = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned dist2(longint ax, longint ay, longint bx, longint by);
        return longint'((ax - bx) * (ax - bx)) + longint'((ay - by) * (ay - by));
    endfunction

    function automatic void queue_placement(logic [2:0] st, int idx, longint x, longint y,
                                            int par, bit last);
        t_placement p;
        p.status       = st;
        p.node_index   = idx[9:0];
        p.node_x       = x[15:0];
        p.node_y       = y[15:0];
        p.parent_index = par[9:0];
        p.last         = last;
        placements_due = {placements_due, p};
    endfunction

    // Predict the results of one accepted transfer and update the shadow tree.
    function automatic void grow_tree(bit mode, longint px, longint py);
        longint          step;
        longint unsigned step2, best, d2, r;
        longint          nx, ny, ox, oy, gx, gy;
        int              nearest, idx;
        step  = longint'(step_lim);
        step2 = step * step;
        if (mode == 1'b0) begin
            node_xs[0]   = px;
            node_ys[0]   = py;
            node_cnt     = 1;
            samples_done = 0;
            goal_hit     = 0;
            started      = 1;
            queue_placement(ST_ROOT, 0, px, py, 0, 1);
            return;
        end
        if (!started || goal_hit || samples_done >= int'(iter_lim) ||
            node_cnt >= MAX_NODES || node_cnt == 0) begin
            queue_placement(ST_IGNORED, 0, 0, 0, 0, 1);
            return;
        end
        nearest = 0;
        best    = 0;
        for (int i = 0; i < node_cnt; i++) begin
            d2 = dist2(node_xs[i], node_ys[i], px, py);
            if (i == 0 || d2 < best) begin
                best    = d2;
                nearest = i;
            end
        end
        if (best <= step2) begin
            nx = px;
            ny = py;
        end else begin
            r = floor_sqrt(best);
            if (r < 1) r = 1;
            nx = node_xs[nearest] + ((px - node_xs[nearest]) * step) / longint'(r);
            ny = node_ys[nearest] + ((py - node_ys[nearest]) * step) / longint'(r);
        end
        samples_done++;
        ox = longint'(obst_x);
        oy = longint'(obst_y);
        if (nx >= ox && nx <= ox + longint'(obst_w) &&
            ny >= oy && ny <= oy + longint'(obst_h)) begin
            queue_placement(ST_REJECT, 0, nx, ny, nearest, 1);
            return;
        end
        idx          = node_cnt;
        node_xs[idx] = nx;
        node_ys[idx] = ny;
        node_cnt++;
        gx = longint'(goal_x);
        gy = longint'(goal_y);
        if (dist2(nx, ny, gx, gy) <= step2 && node_cnt < MAX_NODES) begin
            node_xs[node_cnt] = gx;
            node_ys[node_cnt] = gy;
            goal_hit = 1;
            queue_placement(ST_NODE, idx, nx, ny, nearest, 0);
            queue_placement(ST_GOAL, node_cnt, gx, gy, idx, 1);
            node_cnt++;
        end else begin
            queue_placement(ST_NODE, idx, nx, ny, nearest, 1);
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            o_fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_placement want;
        if (!i_rst_n) begin
            placements_due.delete();
            node_cnt     = 0;
            samples_done = 0;
            goal_hit     = 0;
            started      = 0;
            goal_x   = 16'sd1280;
            goal_y   = 16'sd1280;
            step_lim = 15'd128;
            obst_x   = 16'sd512;
            obst_y   = 16'sd512;
            obst_w   = 15'd256;
            obst_h   = 15'd256;
            iter_lim = 10'd1000;
        end else begin
            // compare first, so a result can never match a transfer taken at this edge
            if (i_out_valid && !i_out_stall) begin
                if (placements_due.size() == 0) begin
                    $error("unexpected result transfer, status %0d", i_status);
                    o_fail_cnt++;
                end else begin
                    want = placements_due.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("node_index", want.node_index, i_node_index);
                    check_field("node_x", want.node_x, i_node_x);
                    check_field("node_y", want.node_y, i_node_y);
                    check_field("parent_index", want.parent_index, i_parent_index);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GOAL_X:     goal_x   = i_cfg_data;
                    REG_GOAL_Y:     goal_y   = i_cfg_data;
                    REG_STEP:       step_lim = i_cfg_data[14:0];
                    REG_OBST_X:     obst_x   = i_cfg_data;
                    REG_OBST_Y:     obst_y   = i_cfg_data;
                    REG_OBST_W:     obst_w   = i_cfg_data[14:0];
                    REG_OBST_H:     obst_h   = i_cfg_data[14:0];
                    REG_ITER_LIMIT: iter_lim = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                grow_tree(i_mode, longint'(i_point_x), longint'(i_point_y));
        end
        o_pending = placements_due.size();
    end

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

endmodule

// ===== verif/tb_rrt_tree_extend.sv =====
// Testbench top for the tree extender: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_rrt_tree_extend;
    import rrt_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 400;   // idle wait before the verdict

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic               i_mode = 0;
    logic signed [15:0] i_point_x = 0;
    logic signed [15:0] i_point_y = 0;
    logic               o_valid;
    logic               i_stall = 0;
    logic [2:0]         o_status;
    logic [9:0]         o_node_index;
    logic signed [15:0] o_node_x;
    logic signed [15:0] o_node_y;
    logic [9:0]         o_parent_index;
    logic               o_last;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_index = REG_GOAL_X;
    logic [15:0]        i_cfg_data = 0;

    int          fail_cnt;
    int          pending;
    int          sent_cnt = 0;
    bit          quiet = 0;       // no idling on either side while set
    logic [15:0] cfg [8];

    rrt_tree_extend dut (.*);

    rrt_tree_extend_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_mode, .i_point_x, .i_point_y,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_status(o_status),
        .i_node_index(o_node_index), .i_node_x(o_node_x), .i_node_y(o_node_y),
        .i_parent_index(o_parent_index), .i_last(o_last), .i_cfg_we, .i_cfg_index,
        .i_cfg_data, .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort on a hung run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("rrt_tree_extend verification failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1;
                hold_left--;
            end else if (!held && sent_cnt >= 80) begin
                held      = 1;
                hold_left = 1500;
                i_stall  <= 1;
            end else begin
                i_stall <= !quiet && ($urandom_range(0, 99) < 35);
            end
        end
    end

    // Offer one transfer; return once it is taken. Valid stays high between items only while quiet is set.
    task automatic send_point(bit mode, int x, int y);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 35) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid   <= 1;
        i_mode    <= mode;
        i_point_x <= x[15:0];
        i_point_y <= y[15:0];
        do @(posedge i_clk); while (o_stall);
        sent_cnt++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write every register from cfg while the block is idle.
    task automatic load_regs();
        wait_idle();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1;
            i_cfg_index <= i[2:0];
            i_cfg_data  <= cfg[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    function automatic int near_coord();
        return int'($urandom_range(0, 3072)) - 1536;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic void pick_regs();
        int r;
        r = $urandom_range(0, 9);
        cfg[REG_GOAL_X]     = (r == 0) ? 16'h8000 : 16'(near_coord());
        cfg[REG_GOAL_Y]     = (r == 1) ? 16'h7fff : 16'(near_coord());
        cfg[REG_STEP]       = (r == 2) ? 16'h7fff : (r == 3) ? 16'd0 : (r == 4) ? 16'd1
                                       : 16'($urandom_range(32, 768));
        cfg[REG_OBST_X]     = (r == 5) ? 16'h8000 : 16'(near_coord());
        cfg[REG_OBST_Y]     = (r == 6) ? 16'h7fff : 16'(near_coord());
        cfg[REG_OBST_W]     = (r == 7) ? 16'h7fff : (r == 8) ? 16'd0
                                       : 16'($urandom_range(0, 1024));
        cfg[REG_OBST_H]     = (r == 8) ? 16'h7fff : (r == 7) ? 16'd0
                                       : 16'($urandom_range(0, 1024));
        cfg[REG_ITER_LIMIT] = (r == 9) ? 16'd1022 : (r == 0) ? 16'd0
                                       : 16'($urandom_range(1, 30));
    endfunction

    initial begin
        int k, n, sx, sy;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: reset register values.
        send_point(1, 0, 0);              // sample before any tree
        send_point(0, 0, 0);
        send_point(1, 32767, 32767);      // steered step
        send_point(1, 0, 100);            // sample within reach
        send_point(1, 0, 50);             // tie between root and node 2
        send_point(0, 600, 600);          // root inside the obstacle is allowed
        send_point(1, 600, 700);          // lands in the obstacle
        send_point(0, 1200, 1200);
        send_point(1, 1250, 1250);        // node then goal
        send_point(1, -100, -100);        // ignored after goal
        send_point(0, -32768, -32768);
        send_point(1, 32767, 32767);
        send_point(1, -32768, 32767);
        send_point(1, 32767, -32768);

        // Zero step and a tiny iteration limit.
        cfg = '{16'd1280, 16'd1280, 16'd0, 16'd512, 16'd512, 16'd256, 16'd256, 16'd2};
        load_regs();
        send_point(0, 0, 0);
        send_point(1, 5, 5);              // node at the nearest node's position
        send_point(1, 0, 0);
        send_point(1, 9, 9);              // limit met
        cfg[REG_ITER_LIMIT] = 16'd0;
        load_regs();
        send_point(0, 0, 0);
        send_point(1, 1, 1);

        // Extremes of the coordinate, step and obstacle registers, with a high iteration limit.
        cfg = '{16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                16'd1022};
        load_regs();
        send_point(0, 100, 100);
        send_point(1, -5, -5);
        send_point(1, 32767, 32767);
        send_point(1, -1, 0);

        // Random phases: mostly short trees with samples around the scene.
        for (int ph = 0; ph < 8; ph++) begin
            pick_regs();
            load_regs();
            quiet = (ph == 3);
            k = 0;
            while (k < 56) begin
                sx = ($urandom_range(0, 9) == 0) ? any_coord() : near_coord();
                sy = ($urandom_range(0, 9) == 0) ? any_coord() : near_coord();
                send_point(0, sx, sy);
                n = $urandom_range(1, 25);
                for (int s = 0; s < n; s++) begin
                    case ($urandom_range(0, 19))
                        0, 1:    send_point(1, any_coord(), any_coord());
                        2:       send_point(1, $signed(cfg[REG_GOAL_X]),
                                            $signed(cfg[REG_GOAL_Y]));
                        default: send_point(1, near_coord(), near_coord());
                    endcase
                end
                k += n + 1;
            end
            quiet = 0;
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("rrt_tree_extend verification clean");
        else
            $display("rrt_tree_extend verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rrt_pkg.sv
sv/rrt_tree_extend.sv
verif/rrt_tree_extend_checker.sv
verif/tb_rrt_tree_extend.sv
